// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	// Field widths
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned TID_W   = 5;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned OUT_W   = 40;

	// Request kinds
	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_SCHED  = 1'b1;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE = 2'd2;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_POP  = 5'b00100,
		S_ADDR = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;      // latch the accepted request
		logic do_create;    // store address, queue new id
		logic do_reject;    // table full result
		logic do_none;      // nothing to run result
		logic do_pop;       // requeue running thread, read queue head
		logic rd_run_addr;  // read address of the running thread
		logic take_pop;     // popped id becomes running, read its address
		logic load_res;     // result from running id and table data
		logic out_load;     // move result into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic kind;
		logic table_full;
		logic queue_empty;
		logic running_none;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl
// Scheduler sequencer: steps one request through queue and table reads.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.kind == KIND_CREATE) begin
					cmd.do_create = !sts.table_full;
					cmd.do_reject = sts.table_full;
					state_d       = S_DONE;
				end else if (sts.queue_empty) begin
					if (sts.running_none) begin
						cmd.do_none = 1'b1;
						state_d     = S_DONE;
					end else begin
						cmd.rd_run_addr = 1'b1;
						state_d         = S_ADDR;
					end
				end else begin
					cmd.do_pop = 1'b1;
					state_d    = S_POP;
				end
			end
			S_POP: begin
				cmd.take_pop = 1'b1;
				state_d      = S_ADDR;
			end
			S_ADDR: begin
				cmd.load_res = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

// ===== rtl/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: id counter, ready queue, address table, result regs.
// ----------------------------------------------------------------------------
module rrts_dp
	import rrts_pkg::*;
#(
	parameter int unsigned MAX_THREADS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              in_kind,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int unsigned PTR_W = $clog2(MAX_THREADS);
	localparam int unsigned ID_W  = $clog2(MAX_THREADS + 2);
	localparam int unsigned CNT_W = $clog2(MAX_THREADS + 1);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_THREADS - 1);
	localparam logic [ID_W-1:0]  ID_MAX   = ID_W'(MAX_THREADS);
	localparam logic [ID_W-1:0]  ID_ONE   = ID_W'(1);

	logic              kind_q;
	logic [ADDR_W-1:0] addr_in_q;
	logic [ID_W-1:0]   next_id_q;
	logic [ID_W-1:0]   running_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [TID_W-1:0]  res_id_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_sw_q;
	logic [ST_W-1:0]   res_st_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              fifo_we;
	logic [ID_W-1:0]   fifo_wdata;
	logic [ID_W-1:0]   fifo_rdata;
	logic              tab_re;
	logic [ID_W-1:0]   tab_rid;
	logic [ADDR_W-1:0] tab_rdata;
	logic              push;
	logic [PTR_W-1:0]  head_inc, tail_inc;

	// Status toward the controller
	assign sts.kind         = kind_q;
	assign sts.table_full   = (next_id_q > ID_MAX);
	assign sts.queue_empty  = (count_q == '0);
	assign sts.running_none = (running_q == '0);
	assign sts.out_free     = !out_valid_q || m_tready;

	// Queue pointer wrap
	assign head_inc = (head_q == PTR_LAST) ? '0 : PTR_W'(head_q + PTR_W'(1));
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : PTR_W'(tail_q + PTR_W'(1));

	// Queue write: new id on create, running id on a switch
	assign push       = cmd.do_pop && !sts.running_none;
	assign fifo_we    = cmd.do_create || push;
	assign fifo_wdata = cmd.do_create ? next_id_q : running_q;

	// Table read: popped id or running id
	assign tab_re  = cmd.take_pop || cmd.rd_run_addr;
	assign tab_rid = cmd.take_pop ? fifo_rdata : running_q;

	rrts_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_THREADS)
	) u_ready_q (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (tail_q),
		.wdata (fifo_wdata),
		.re    (cmd.do_pop),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	rrts_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (MAX_THREADS)
	) u_addr_tab (
		.clk   (clk),
		.we    (cmd.do_create),
		.waddr (PTR_W'(next_id_q - ID_ONE)),
		.wdata (addr_in_q),
		.re    (tab_re),
		.raddr (PTR_W'(tab_rid - ID_ONE)),
		.rdata (tab_rdata)
	);

	// Request latch, payload only
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q    <= in_kind;
			addr_in_q <= in_addr;
		end
	end

	// Scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= ID_ONE;
			running_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.do_create) begin
				next_id_q <= ID_W'(next_id_q + ID_ONE);
				tail_q    <= tail_inc;
				count_q   <= CNT_W'(count_q + CNT_W'(1));
			end
			if (cmd.do_pop) begin
				head_q <= head_inc;
				if (push) begin
					tail_q <= tail_inc;
				end else begin
					count_q <= CNT_W'(count_q - CNT_W'(1));
				end
			end
			if (cmd.take_pop) begin
				running_q <= fifo_rdata;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.do_create) begin
			res_id_q   <= TID_W'(next_id_q);
			res_addr_q <= addr_in_q;
			res_sw_q   <= 1'b0;
			res_st_q   <= ST_OK;
		end
		if (cmd.do_reject || cmd.do_none) begin
			res_id_q   <= '0;
			res_addr_q <= '0;
			res_sw_q   <= 1'b0;
			res_st_q   <= cmd.do_reject ? ST_FULL : ST_NONE;
		end
		if (cmd.do_pop) begin
			res_sw_q <= 1'b1;
		end
		if (cmd.rd_run_addr) begin
			res_sw_q <= 1'b0;
		end
		if (cmd.load_res) begin
			res_id_q   <= TID_W'(running_q);
			res_addr_q <= tab_rdata;
			res_st_q   <= ST_OK;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {res_st_q, res_sw_q, res_addr_q, res_id_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/round_robin_thread_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Round-robin thread scheduler with a FIFO ready queue and address table.
// ----------------------------------------------------------------------------
// Each request beat returns exactly one result beat. A create, or a schedule
// when no thread exists, goes from the execute state to the done state; a
// schedule with an empty queue but a running thread passes through the
// address state, and a switch passes through the pop and address states.
// With a free output register the next request is taken in the following
// cycle. The extra states come from the registered read ports of the
// ready-queue RAM and the address-table RAM, which are read one after the
// other on a switch. One request is in flight at a time; a finished result
// sits in the output register while the next request is accepted, and the
// block stalls only when that register is still full at completion.
// Ids run from 1 to MAX_THREADS; creates beyond that report table full.
module round_robin_thread_scheduler_core
	import rrts_pkg::*;
#(
	parameter int unsigned MAX_THREADS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ADDR_W-1:0] s_tdata,   // [31:0] entry_addr
	input  logic              s_tuser,   // [0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata    // [4:0] tid, [36:5] thread_address,
	                                     // [37] switched, [39:38] status
);

	cmd_t cmd;
	sts_t sts;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrts_dp #(
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_kind  (s_tuser),
		.in_addr  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the round-robin thread scheduler core. Request beats
// come from a queue filled at time zero: a directed opening covers the empty
// scheduler, the first switch, a lone running thread, address extremes and
// the full thread table. After that come random schedule and create beats.
// A local scheduler model predicts every result beat, and the monitor
// compares each returned beat field by field. Both sides idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
	import rrts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_THREADS = 16;
	localparam int unsigned N_RANDOM    = 1000;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES = 200;

	// One request beat together with the idle cycles placed ahead of it
	typedef struct {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		int unsigned       gap;
	} request_t;

	// One result beat, as unpacked from m_tdata
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              switched;
		logic [ADDR_W-1:0] taddr;
		logic [TID_W-1:0]  tid;
	} dispatch_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [ADDR_W-1:0] s_tdata  = '0;
	logic              s_tuser  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// Stimulus and expected results
	request_t    pending_requests[$];
	dispatch_t   expected_dispatch[$];
	request_t    cur_req;
	logic        have_req  = 1'b0;
	int unsigned gap_left  = 0;
	int unsigned beats_in  = 0;
	int unsigned beats_out = 0;
	int unsigned n_total   = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned errors    = 0;
	logic        hold      = 1'b0;

	// Scheduler model state
	int unsigned       mdl_next_id = 1;
	logic [TID_W-1:0]  mdl_running = '0;
	logic [TID_W-1:0]  mdl_ready[$];
	logic [ADDR_W-1:0] mdl_addr[1:MAX_THREADS];

	round_robin_thread_scheduler_core #(
		.MAX_THREADS(MAX_THREADS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// Model step: one request in, one dispatch result out
	function automatic dispatch_t predict_dispatch(logic kind, logic [ADDR_W-1:0] addr);
		dispatch_t r;
		r = '0;
		if (kind == KIND_CREATE) begin
			if (mdl_next_id > MAX_THREADS) begin
				r.status = ST_FULL;
			end else begin
				r.tid = mdl_next_id[TID_W-1:0];
				r.taddr = addr;
				mdl_addr[mdl_next_id] = addr;
				mdl_ready.insert(mdl_ready.size(), mdl_next_id[TID_W-1:0]);
				mdl_next_id++;
			end
		end else if (mdl_ready.size() == 0) begin
			// nothing queued: report the running thread, if any
			r.tid = mdl_running;
			if (mdl_running == 0) begin
				r.status = ST_NONE;
			end else begin
				r.taddr = mdl_addr[mdl_running];
			end
		end else begin
			// requeue the running thread, then take the head
			if (mdl_running != 0)
				mdl_ready.insert(mdl_ready.size(), mdl_running);
			mdl_running = mdl_ready.pop_front();
			r.tid = mdl_running;
			r.taddr = mdl_addr[mdl_running];
			r.switched = 1'b1;
		end
		return r;
	endfunction

	// Queue a request; idle gaps come in bands, with gap-free bands between
	function automatic void queue_request(logic kind, logic [ADDR_W-1:0] addr);
		request_t rq;
		int unsigned idx;
		idx = n_total;
		rq.kind = kind;
		rq.addr = addr;
		rq.gap = ((idx / 80) % 3 == 0) ? 0 : $urandom_range(0, 12);
		pending_requests.insert(pending_requests.size(), rq);
		n_total++;
	endfunction

	task automatic flag_mismatch(string what);
		$display("ERROR @%0t: %s", $realtime, what);
		errors++;
	endtask

	// Driver: presents pending requests on the slave side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_dispatch.insert(expected_dispatch.size(),
					predict_dispatch(s_tuser, s_tdata));
				beats_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (!have_req && pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					have_req = 1'b1;
					gap_left = cur_req.gap;
				end
				if (have_req && gap_left == 0) begin
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.kind;
					s_tdata <= cur_req.addr;
					have_req = 1'b0;
				end else begin
					s_tvalid <= 1'b0;
					if (have_req)
						gap_left--;
				end
			end
		end
	end

	// Monitor: accepts result beats and checks them against the model
	always @(posedge clk or negedge arst_n) begin
		dispatch_t got;
		dispatch_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_dispatch.size() == 0) begin
					flag_mismatch($sformatf("result beat with none expected: %h", m_tdata));
				end else begin
					want = expected_dispatch.pop_front();
					if (got.tid !== want.tid)
						flag_mismatch($sformatf("beat %0d tid %0d, want %0d",
							beats_out, got.tid, want.tid));
					if (got.taddr !== want.taddr)
						flag_mismatch($sformatf("beat %0d thread_address %h, want %h",
							beats_out, got.taddr, want.taddr));
					if (got.switched !== want.switched)
						flag_mismatch($sformatf("beat %0d switched %b, want %b",
							beats_out, got.switched, want.switched));
					if (got.status !== want.status)
						flag_mismatch($sformatf("beat %0d status %0d, want %0d",
							beats_out, got.status, want.status));
				end
				beats_out++;
				// stall bands alternate with stall-free bands
				stall_left = ((beats_out / 90) % 3 == 1) ? 0 : $urandom_range(0, 12);
			end
			if (hold || stall_left > 0) begin
				m_tready <= 1'b0;
				if (stall_left > 0)
					stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run after a long stretch with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Long receiver hold-off so the core backs up and stalls its input
	initial begin
		wait (beats_out >= 400);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	// Stimulus, reset and end of run
	initial begin
		// empty scheduler, then a single thread
		queue_request(KIND_SCHED, $urandom);
		queue_request(KIND_CREATE, 32'h0000_0000);
		queue_request(KIND_SCHED, $urandom);
		queue_request(KIND_SCHED, $urandom);
		// second thread, rotate both ways
		queue_request(KIND_CREATE, 32'hFFFF_FFFF);
		queue_request(KIND_SCHED, 32'h0000_0000);
		queue_request(KIND_SCHED, 32'hFFFF_FFFF);
		queue_request(KIND_CREATE, 32'hAAAA_AAAA);
		queue_request(KIND_CREATE, 32'h5555_5555);
		// fill the thread table, then one create too many
		for (int i = 5; i <= MAX_THREADS; i++)
			queue_request(KIND_CREATE, $urandom);
		queue_request(KIND_CREATE, 32'hFFFF_FFFF);
		queue_request(KIND_SCHED, $urandom);
		queue_request(KIND_SCHED, $urandom);

		// random mix: mostly schedules, creates are now rejected
		for (int i = 0; i < N_RANDOM; i++)
			queue_request(($urandom_range(0, 3) == 0) ? KIND_CREATE : KIND_SCHED, $urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_in < n_total)
			@(posedge clk);
		while (expected_dispatch.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
